FILE: rtl/core/qte_pkg.sv
`default_nettype none
package qte_pkg;

  // Fixed-width angle path: 32-bit binary angle (pi = 2^31) plus headroom.
  localparam int ACC_BITS   = 34;
  localparam int WORK_BITS  = 30;
  localparam int ROOT_BITS  = WORK_BITS + 1;
  localparam int RAD_BITS   = 2 * WORK_BITS + 1;
  localparam int PITCH_BITS = ROOT_BITS + 3;
  localparam int TABLE_LEN  = 24;

  localparam int LANE_PITCH   = 0;
  localparam int LANE_HEADING = 1;
  localparam int LANE_BANK    = 2;
  localparam int NUM_LANES    = 3;

  localparam logic signed [ACC_BITS-1:0] ACC_HALF_PI = 34'sd1073741824;
  localparam logic signed [ACC_BITS-1:0] ACC_ROUND   = 34'sd32768;
  localparam logic signed [ACC_BITS-1:0] PITCH_MAX   = 34'sd16384;

  localparam logic [14:0] THRESHOLD_RESET = 15'd16384;

  localparam logic [31:0] ANGLE_STEP [TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic lock;
    logic clamped;
    logic neg;
  } qte_flags_t;

endpackage
`default_nettype wire

FILE: rtl/core/qte_ifs.sv
`default_nettype none
interface qte_quat_if #(parameter int QB = 16);
  logic                 valid;
  logic                 ready;
  logic signed [QB-1:0] quat_w;
  logic signed [QB-1:0] quat_x;
  logic signed [QB-1:0] quat_y;
  logic signed [QB-1:0] quat_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_euler_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] heading_angle;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] bank_angle;
  logic               gimbal_lock;
  logic               sine_clamped;
  modport source (output valid, heading_angle, pitch_angle, bank_angle, gimbal_lock,
                  sine_clamped, input ready);
  modport sink   (input valid, heading_angle, pitch_angle, bank_angle, gimbal_lock,
                  sine_clamped, output ready);
endinterface

interface qte_cfg_if;
  logic        valid;
  logic        ready;
  logic [14:0] gimbal_threshold;
  modport source (output valid, gimbal_threshold, input ready);
  modport sink   (input valid, gimbal_threshold, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/qte_front.sv
`default_nettype none
module qte_front #(
  parameter int QB = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic signed [QB-1:0]        w,
  input  wire logic signed [QB-1:0]        x,
  input  wire logic signed [QB-1:0]        y,
  input  wire logic signed [QB-1:0]        z,
  input  wire logic [14:0]                 thr,
  output logic                             out_valid,
  output logic [qte_pkg::RAD_BITS-1:0]     rad,
  output logic [qte_pkg::ROOT_BITS-1:0]    mag30,
  output qte_pkg::qte_flags_t              flags,
  output logic signed [2*QB:0]             hd_y,
  output logic signed [2*QB:0]             hd_x,
  output logic signed [2*QB:0]             bk_y,
  output logic signed [2*QB:0]             bk_x
);
  localparam int PW = 2 * QB;
  localparam int OW = PW + 1;
  localparam int PB = 2 * (QB - 2);
  localparam int RB = qte_pkg::RAD_BITS;
  localparam int MB = qte_pkg::ROOT_BITS;
  localparam logic signed [PW+1:0] S_ONE = {{(PW+1-PB){1'b0}}, 1'b1, {PB{1'b0}}};
  localparam logic signed [OW-1:0] HALF  = {{(OW-PB){1'b0}}, 1'b1, {(PB-1){1'b0}}};
  localparam logic [RB-1:0] RAD_ONE = {1'b1, {(RB-1){1'b0}}};

  // stage A: products
  logic                 a_v_r;
  logic signed [PW-1:0] p_yz_r, p_wx_r, p_xz_r, p_wy_r, p_xy_r, p_wz_r, p_xx_r, p_yy_r, p_zz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_yz_r <= y * z;
      p_wx_r <= w * x;
      p_xz_r <= x * z;
      p_wy_r <= w * y;
      p_xy_r <= x * y;
      p_wz_r <= w * z;
      p_xx_r <= x * x;
      p_yy_r <= y * y;
      p_zz_r <= z * z;
    end
  end

  // stage B: pitch sine, clamp, lock decision, atan2 operands
  logic signed [PW:0]   sum;
  logic signed [PW+1:0] s_raw, s_cl, mag_full;
  logic [PB:0]          mag;
  logic [PB+30:0]       mag_ext;
  qte_pkg::qte_flags_t  fl_nxt;
  logic signed [OW-1:0] hd_y_nxt, hd_x_nxt, bk_y_nxt, bk_x_nxt;

  always_comb begin
    sum = OW'(p_yz_r) + OW'(p_wx_r);
    s_raw = -$signed({sum, 1'b0});
    fl_nxt = '0;
    s_cl = s_raw;
    if (s_raw > S_ONE) begin
      s_cl = S_ONE;
      fl_nxt.clamped = 1'b1;
    end else if (s_raw < -S_ONE) begin
      s_cl = -S_ONE;
      fl_nxt.clamped = 1'b1;
    end
    fl_nxt.neg = s_cl[PW+1];
    mag_full = fl_nxt.neg ? -s_cl : s_cl;
    mag = mag_full[PB:0];
    fl_nxt.lock = (mag >= {thr, {(PB-14){1'b0}}});
    mag_ext = {mag, 30'b0} >> PB;
    if (fl_nxt.lock) begin
      hd_y_nxt = -OW'(p_xz_r) - OW'(p_wy_r);
      hd_x_nxt = HALF - OW'(p_yy_r) - OW'(p_zz_r);
      bk_y_nxt = '0;
      bk_x_nxt = '0;
    end else begin
      hd_y_nxt = OW'(p_xz_r) - OW'(p_wy_r);
      hd_x_nxt = HALF - OW'(p_xx_r) - OW'(p_yy_r);
      bk_y_nxt = OW'(p_xy_r) - OW'(p_wz_r);
      bk_x_nxt = HALF - OW'(p_xx_r) - OW'(p_zz_r);
    end
  end

  logic                 b_v_r;
  logic [MB-1:0]        b_mag_r;
  qte_pkg::qte_flags_t  b_fl_r;
  logic signed [OW-1:0] b_hy_r, b_hx_r, b_by_r, b_bx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_mag_r <= mag_ext[MB-1:0];
      b_fl_r  <= fl_nxt;
      b_hy_r  <= hd_y_nxt;
      b_hx_r  <= hd_x_nxt;
      b_by_r  <= bk_y_nxt;
      b_bx_r  <= bk_x_nxt;
    end
  end

  // stage C: radicand 1 - s^2 at 60 fraction bits
  logic [2*MB-1:0] sq;
  logic            c_v_r;

  assign sq = b_mag_r * b_mag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (en) begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad   <= RAD_ONE - sq[RB-1:0];
      mag30 <= b_mag_r;
      flags <= b_fl_r;
      hd_y  <= b_hy_r;
      hd_x  <= b_hx_r;
      bk_y  <= b_by_r;
      bk_x  <= b_bx_r;
    end
  end

  assign out_valid = c_v_r;
endmodule
`default_nettype wire

FILE: rtl/core/qte_sqrt.sv
`default_nettype none
module qte_sqrt #(
  parameter int SIDE_W = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             en,
  input  wire logic                             in_valid,
  input  wire logic [qte_pkg::RAD_BITS-1:0]     rad,
  input  wire logic [SIDE_W-1:0]                side_in,
  output logic                                  out_valid,
  output logic [qte_pkg::ROOT_BITS-1:0]         root,
  output logic [SIDE_W-1:0]                     side_out
);
  localparam int NB = qte_pkg::ROOT_BITS;
  localparam int RW = qte_pkg::RAD_BITS + 2;

  // One result bit per stage, most significant first.
  logic            v_r    [NB];
  logic [RW-1:0]   rem_r  [NB];
  logic [NB-1:0]   root_r [NB];
  logic [SIDE_W-1:0] side_r [NB];

  for (genvar j = 0; j < NB; j++) begin : g_st
    localparam int K = NB - 1 - j;
    logic              v_i;
    logic [RW-1:0]     rem_i;
    logic [NB-1:0]     root_i;
    logic [SIDE_W-1:0] side_i;
    logic [RW-1:0]     trial;

    if (j == 0) begin : g_first
      assign v_i    = in_valid;
      assign rem_i  = RW'(rad);
      assign root_i = '0;
      assign side_i = side_in;
    end else begin : g_next
      assign v_i    = v_r[j-1];
      assign rem_i  = rem_r[j-1];
      assign root_i = root_r[j-1];
      assign side_i = side_r[j-1];
    end

    assign trial = (RW'(root_i) << (K + 1)) + (RW'(1) << (2 * K));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[j] <= side_i;
        if (rem_i >= trial) begin
          rem_r[j]  <= rem_i - trial;
          root_r[j] <= root_i | (NB'(1) << K);
        end else begin
          rem_r[j]  <= rem_i;
          root_r[j] <= root_i;
        end
      end
    end
  end

  assign out_valid = v_r[NB-1];
  assign root      = root_r[NB-1];
  assign side_out  = side_r[NB-1];
endmodule
`default_nettype wire

FILE: rtl/core/qte_cordic.sv
`default_nettype none
module qte_cordic #(
  parameter int W      = 36,
  parameter int STAGES = 16,
  parameter int LANES  = 3,
  parameter int SIDE_W = 3
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire logic                                        en,
  input  wire logic                                        in_valid,
  input  wire logic [LANES-1:0][W-1:0]                     y_in,
  input  wire logic [LANES-1:0][W-1:0]                     x_in,
  input  wire logic [SIDE_W-1:0]                           side_in,
  output logic                                             out_valid,
  output logic [LANES-1:0][qte_pkg::ACC_BITS-1:0]          angle,
  output logic [SIDE_W-1:0]                                side_out
);
  localparam int AB = qte_pkg::ACC_BITS;

  logic              v_r    [STAGES+1];
  logic [SIDE_W-1:0] side_r [STAGES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= STAGES; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int i = 1; i <= STAGES; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_in;
      for (int i = 1; i <= STAGES; i++) side_r[i] <= side_r[i-1];
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic signed [W-1:0]  xi, yi, fx, fy;
    logic signed [AB-1:0] fa;
    logic signed [W-1:0]  x_r [STAGES+1];
    logic signed [W-1:0]  y_r [STAGES+1];
    logic signed [AB-1:0] a_r [STAGES+1];
    logic                 z_r [STAGES+1];

    assign xi = $signed(x_in[l]);
    assign yi = $signed(y_in[l]);

    // fold the left half plane into the right by a quarter turn
    always_comb begin
      fx = xi;
      fy = yi;
      fa = '0;
      if (xi[W-1]) begin
        if (!yi[W-1]) begin
          fx = yi;
          fy = -xi;
          fa = qte_pkg::ACC_HALF_PI;
        end else begin
          fx = -yi;
          fy = xi;
          fa = -qte_pkg::ACC_HALF_PI;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[0] <= fx;
        y_r[0] <= fy;
        a_r[0] <= fa;
        z_r[0] <= (xi == '0) && (yi == '0);
        for (int i = 0; i < STAGES; i++) begin
          z_r[i+1] <= z_r[i];
          if (!y_r[i][W-1]) begin
            x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
            y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
            a_r[i+1] <= a_r[i] + $signed({{(AB-32){1'b0}}, qte_pkg::ANGLE_STEP[i]});
          end else begin
            x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
            y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
            a_r[i+1] <= a_r[i] - $signed({{(AB-32){1'b0}}, qte_pkg::ANGLE_STEP[i]});
          end
        end
      end
    end

    assign angle[l] = z_r[STAGES] ? '0 : a_r[STAGES];
  end

  assign out_valid = v_r[STAGES];
  assign side_out  = side_r[STAGES];
endmodule
`default_nettype wire

FILE: rtl/core/quaternion_to_euler_angles_top.sv
`default_nettype none
// Quaternion to heading / pitch / bank. Takes a quaternion (w, x, y, z) in
// signed Q1.(QUAT_BITS-2) and returns heading, pitch and bank as 16-bit binary
// angles (32768 = pi), plus a gimbal-lock flag and a flag that the pitch sine
// was clamped to +-1. One beat is accepted every cycle while the skid entry is
// empty. The pipeline runs through the 31-stage bit-per-stage square root
// and the CORDIC_STAGES-deep vectoring CORDIC that runs the three atan2
// lanes side by side. A two-entry output (register plus skid) keeps the
// input ready while a finished result waits; input ready is registered.
// gimbal_threshold is written on the cfg port; write it only while idle.
module quaternion_to_euler_angles_top #(
  parameter int CORDIC_STAGES = 16,
  parameter int QUAT_BITS     = 16
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  qte_quat_if.sink     in_bus,
  qte_euler_if.source  out_bus,
  qte_cfg_if.sink      cfg_bus
);
  localparam int OW  = 2 * QUAT_BITS + 1;
  localparam int CW  = (2 * QUAT_BITS + 4 > qte_pkg::PITCH_BITS) ?
                       2 * QUAT_BITS + 4 : qte_pkg::PITCH_BITS;
  localparam int MB  = qte_pkg::ROOT_BITS;
  localparam int FW  = $bits(qte_pkg::qte_flags_t);
  localparam int SW  = FW + 4 * OW + MB;
  localparam int AB  = qte_pkg::ACC_BITS;

  // Configuration: always ready, one register.
  logic [14:0] thr_r;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= qte_pkg::THRESHOLD_RESET;
    end else if (cfg_bus.valid) begin
      thr_r <= cfg_bus.gimbal_threshold;
    end
  end

  // The whole pipeline advances together unless the skid entry is occupied.
  logic sk_v_r;
  logic adv;

  assign adv          = ~sk_v_r;
  assign in_bus.ready = adv;

  // Front end: products, sine, clamp, lock, radicand.
  logic                 fr_v;
  logic [qte_pkg::RAD_BITS-1:0] fr_rad;
  logic [MB-1:0]        fr_mag;
  qte_pkg::qte_flags_t  fr_fl;
  logic signed [OW-1:0] fr_hy, fr_hx, fr_by, fr_bx;

  qte_front #(.QB(QUAT_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (in_bus.valid),
    .w         (in_bus.quat_w),
    .x         (in_bus.quat_x),
    .y         (in_bus.quat_y),
    .z         (in_bus.quat_z),
    .thr       (thr_r),
    .out_valid (fr_v),
    .rad       (fr_rad),
    .mag30     (fr_mag),
    .flags     (fr_fl),
    .hd_y      (fr_hy),
    .hd_x      (fr_hx),
    .bk_y      (fr_by),
    .bk_x      (fr_bx)
  );

  // Square root of 1 - s^2; carry everything else alongside.
  logic                 sq_v;
  logic [MB-1:0]        sq_root;
  logic [SW-1:0]        sq_side;
  qte_pkg::qte_flags_t  sq_fl;
  logic signed [OW-1:0] sq_hy, sq_hx, sq_by, sq_bx;
  logic [MB-1:0]        sq_mag;

  qte_sqrt #(.SIDE_W(SW)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (fr_v),
    .rad       (fr_rad),
    .side_in   ({fr_fl, fr_hy, fr_hx, fr_by, fr_bx, fr_mag}),
    .out_valid (sq_v),
    .root      (sq_root),
    .side_out  (sq_side)
  );

  assign {sq_fl, sq_hy, sq_hx, sq_by, sq_bx, sq_mag} = sq_side;

  // Three atan2 lanes: pitch = atan2(+-s, sqrt(1 - s^2)), heading, bank.
  logic [qte_pkg::NUM_LANES-1:0][CW-1:0] cy, cx;
  logic signed [CW-1:0] mag_ext;

  assign mag_ext = CW'($signed({1'b0, sq_mag}));

  always_comb begin
    cy[qte_pkg::LANE_PITCH]   = sq_fl.neg ? -mag_ext : mag_ext;
    cx[qte_pkg::LANE_PITCH]   = CW'($signed({1'b0, sq_root}));
    cy[qte_pkg::LANE_HEADING] = CW'(sq_hy);
    cx[qte_pkg::LANE_HEADING] = CW'(sq_hx);
    cy[qte_pkg::LANE_BANK]    = CW'(sq_by);
    cx[qte_pkg::LANE_BANK]    = CW'(sq_bx);
  end

  logic                                  co_v;
  logic [qte_pkg::NUM_LANES-1:0][AB-1:0] co_ang;
  qte_pkg::qte_flags_t                   co_fl;

  qte_cordic #(
    .W      (CW),
    .STAGES (CORDIC_STAGES),
    .LANES  (qte_pkg::NUM_LANES),
    .SIDE_W (FW)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (sq_v),
    .y_in      (cy),
    .x_in      (cx),
    .side_in   (sq_fl),
    .out_valid (co_v),
    .angle     (co_ang),
    .side_out  (co_fl)
  );

  // Round half up to 16 bits; saturate pitch to +-half pi. Heading and bank
  // wrap, so pi comes out as -32768.
  logic signed [AB-1:0] r_p, r_h, r_b, p_sat;

  always_comb begin
    r_p = ($signed(co_ang[qte_pkg::LANE_PITCH]) + qte_pkg::ACC_ROUND) >>> 16;
    r_h = ($signed(co_ang[qte_pkg::LANE_HEADING]) + qte_pkg::ACC_ROUND) >>> 16;
    r_b = ($signed(co_ang[qte_pkg::LANE_BANK]) + qte_pkg::ACC_ROUND) >>> 16;
    p_sat = r_p;
    if (r_p > qte_pkg::PITCH_MAX) begin
      p_sat = qte_pkg::PITCH_MAX;
    end else if (r_p < -qte_pkg::PITCH_MAX) begin
      p_sat = -qte_pkg::PITCH_MAX;
    end
  end

  logic               rd_v_r;
  logic signed [15:0] rd_h_r, rd_p_r, rd_b_r;
  logic               rd_lock_r, rd_clamp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else if (adv) begin
      rd_v_r <= co_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_h_r     <= r_h[15:0];
      rd_p_r     <= p_sat[15:0];
      rd_b_r     <= r_b[15:0];
      rd_lock_r  <= co_fl.lock;
      rd_clamp_r <= co_fl.clamped;
    end
  end

  // Output register plus skid entry. A beat leaving the rounding stage goes
  // to the output register when it is free or draining, else into the skid.
  logic               out_v_r;
  logic signed [15:0] out_h_r, out_p_r, out_b_r;
  logic               out_lock_r, out_clamp_r;
  logic signed [15:0] sk_h_r, sk_p_r, sk_b_r;
  logic               sk_lock_r, sk_clamp_r;
  logic               take_rd, load_out, load_sk;

  assign take_rd  = adv && rd_v_r;
  assign load_out = take_rd && (!out_v_r || out_bus.ready);
  assign load_sk  = take_rd && out_v_r && !out_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else begin
      if (sk_v_r) begin
        out_v_r <= 1'b1;
        if (out_bus.ready) begin
          sk_v_r <= 1'b0;
        end
      end else if (take_rd) begin
        out_v_r <= 1'b1;
        sk_v_r  <= load_sk;
      end else if (out_bus.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sk_v_r && out_bus.ready) begin
      out_h_r     <= sk_h_r;
      out_p_r     <= sk_p_r;
      out_b_r     <= sk_b_r;
      out_lock_r  <= sk_lock_r;
      out_clamp_r <= sk_clamp_r;
    end else if (load_out) begin
      out_h_r     <= rd_h_r;
      out_p_r     <= rd_p_r;
      out_b_r     <= rd_b_r;
      out_lock_r  <= rd_lock_r;
      out_clamp_r <= rd_clamp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load_sk) begin
      sk_h_r     <= rd_h_r;
      sk_p_r     <= rd_p_r;
      sk_b_r     <= rd_b_r;
      sk_lock_r  <= rd_lock_r;
      sk_clamp_r <= rd_clamp_r;
    end
  end

  assign out_bus.valid         = out_v_r;
  assign out_bus.heading_angle = out_h_r;
  assign out_bus.pitch_angle   = out_p_r;
  assign out_bus.bank_angle    = out_b_r;
  assign out_bus.gimbal_lock   = out_lock_r;
  assign out_bus.sine_clamped  = out_clamp_r;

`ifndef SYNTH
  // The skid entry fills only behind a stalled output beat.
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(sk_v_r) |-> $past(out_v_r && !out_bus.ready))
    else $error("skid entry filled while output was free");

  // A delivered pitch never leaves the half-pi range.
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_p_r <= 16'sd16384 && out_p_r >= -16'sd16384))
    else $error("pitch outside half-pi range");

  // Under gimbal lock the bank lane sees a zero vector.
  a_lock_bank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_lock_r) |-> (out_b_r == 16'sd0))
    else $error("bank nonzero under gimbal lock");
`endif
endmodule
`default_nettype wire

FILE: test/tb_quaternion_to_euler_angles_top.sv
module tb_quaternion_to_euler_angles_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STAGES    = 16;
  localparam int QB        = 16;
  localparam int FRAC      = QB - 2;
  localparam int PROD      = 2 * FRAC;
  localparam int LATENCY   = 3 + 31 + (STAGES + 1) + 2;
  localparam int RAND_BEATS = 950;

  typedef struct {
    logic signed [QB-1:0] w, x, y, z;
  } quat_t;

  typedef struct {
    logic signed [15:0] heading;
    logic signed [15:0] pitch;
    logic signed [15:0] bank;
    logic               lock;
    logic               clamped;
  } euler_t;

  typedef enum int {SHAPE_UNIT, SHAPE_NEAR_LOCK, SHAPE_RAW} quat_shape_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  qte_quat_if #(.QB(QB)) in_if ();
  qte_euler_if           out_if ();
  qte_cfg_if             cfg_if ();

  quaternion_to_euler_angles_top #(.CORDIC_STAGES(STAGES), .QUAT_BITS(QB)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if.sink),
    .out_bus (out_if.source),
    .cfg_bus (cfg_if.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus and scoreboard storage.
  quat_t         quat_q[$];
  euler_t        euler_expected_q[$];
  logic [14:0]   threshold_q[$];
  logic [14:0]   threshold_now = qte_pkg::THRESHOLD_RESET;

  int mismatch_count = 0;
  int beats_in       = 0;
  int beats_out      = 0;
  int locks_seen     = 0;
  int clamps_seen    = 0;
  int thresholds_set = 0;

  task automatic report(input string what, input logic signed [31:0] got,
                        input logic signed [31:0] want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Predictor: fixed-point asin / atan2 through a vectoring CORDIC.
  // ---------------------------------------------------------------------------
  function automatic longint unsigned floor_root(input longint unsigned d);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > d) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (d >= res + bitv) begin
        d   = d - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Angle of (xv, yv) with pi = 2^31.
  function automatic longint cordic_angle(input longint yv, input longint xv);
    longint acc, t, dx, dy;
    acc = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      t = xv;
      if (yv >= 0) begin
        xv = yv;  yv = -t; acc = 64'sd1 << 30;
      end else begin
        xv = -yv; yv = t;  acc = -(64'sd1 << 30);
      end
    end
    for (int i = 0; i < STAGES && i < qte_pkg::TABLE_LEN; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv >= 0) begin
        xv += dx; yv -= dy; acc += longint'(qte_pkg::ANGLE_STEP[i]);
      end else begin
        xv -= dx; yv += dy; acc -= longint'(qte_pkg::ANGLE_STEP[i]);
      end
    end
    return acc;
  endfunction

  function automatic logic signed [15:0] short_angle(input longint acc);
    longint r;
    r = (acc + 32768) >>> 16;
    return r[15:0];
  endfunction

  function automatic euler_t euler_predict(input quat_t q, input logic [14:0] thr);
    longint w, x, y, z, one, half, s, mag, pitch;
    longint unsigned mag30, c30;
    logic neg;
    euler_t e;
    w = q.w; x = q.x; y = q.y; z = q.z;
    one  = 64'sd1 << PROD;
    half = 64'sd1 << (PROD - 1);
    s = -2 * (y * z + w * x);
    e.clamped = 1'b0;
    if (s > one)  begin s = one;  e.clamped = 1'b1; end
    if (s < -one) begin s = -one; e.clamped = 1'b1; end
    neg = s < 0;
    mag = neg ? -s : s;
    e.lock = mag >= (longint'(thr) << (PROD - 14));

    mag30 = longint'(mag) << (qte_pkg::WORK_BITS - PROD);
    c30   = floor_root((64'd1 << 60) - mag30 * mag30);
    pitch = (cordic_angle(neg ? -longint'(mag30) : longint'(mag30), longint'(c30)) + 32768)
            >>> 16;
    if (pitch > 16384)  pitch = 16384;
    if (pitch < -16384) pitch = -16384;
    e.pitch = pitch[15:0];

    if (!e.lock) begin
      e.heading = short_angle(cordic_angle(x * z - w * y, half - x * x - y * y));
      e.bank    = short_angle(cordic_angle(x * y - w * z, half - x * x - z * z));
    end else begin
      e.heading = short_angle(cordic_angle(-x * z - w * y, half - y * y - z * z));
      e.bank    = '0;
    end
    return e;
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: bursts of random length separated by random gaps.
  // ---------------------------------------------------------------------------
  int burst_left = 4;
  int gap_left   = 0;

  always @(posedge clk) begin
    quat_t q;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      // Predict on the accepted beat, using the values held on the bus.
      if (in_if.valid && in_if.ready) begin
        q.w = in_if.quat_w; q.x = in_if.quat_x; q.y = in_if.quat_y; q.z = in_if.quat_z;
        euler_expected_q.push_back(euler_predict(q, threshold_now));
        beats_in++;
      end
      // Advance to the next beat only when the bus is free.
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (quat_q.size() > 0) begin
          q = quat_q.pop_front();
          in_if.quat_w <= q.w;
          in_if.quat_x <= q.x;
          in_if.quat_y <= q.y;
          in_if.quat_z <= q.z;
          in_if.valid  <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            // Every fourth burst or so runs back to back with the next.
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Config driver: one register, written from a queue of pending values.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_if.valid <= 1'b0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        threshold_now = cfg_if.gimbal_threshold;
        thresholds_set++;
      end
      if (!cfg_if.valid || cfg_if.ready) begin
        if (threshold_q.size() > 0) begin
          cfg_if.gimbal_threshold <= threshold_q.pop_front();
          cfg_if.valid            <= 1'b1;
        end else begin
          cfg_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor with its own stall pattern: the mode is picked at random
  // from always ready, light random stall, heavy random stall and a
  // periodic on/off stall.
  // ---------------------------------------------------------------------------
  int stall_cycle = 0;
  int stall_mode  = 0;

  always @(posedge clk) begin
    euler_t e;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        beats_out++;
        if (euler_expected_q.size() == 0) begin
          report("result beat with nothing expected", 32'sd1, 32'sd0);
        end else begin
          e = euler_expected_q.pop_front();
          if (out_if.heading_angle !== e.heading) report("heading", out_if.heading_angle, e.heading);
          if (out_if.pitch_angle !== e.pitch)     report("pitch", out_if.pitch_angle, e.pitch);
          if (out_if.bank_angle !== e.bank)       report("bank", out_if.bank_angle, e.bank);
          if (out_if.gimbal_lock !== e.lock)      report("gimbal_lock", out_if.gimbal_lock, e.lock);
          if (out_if.sine_clamped !== e.clamped)
            report("sine_clamped", out_if.sine_clamped, e.clamped);
          if (e.lock)    locks_seen++;
          if (e.clamped) clamps_seen++;
        end
      end
      stall_cycle++;
      if (stall_cycle % 64 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 7) != 0);
        2: out_if.ready <= ($urandom_range(0, 3) == 0);
        default: out_if.ready <= ((stall_cycle / 5) % 2 == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus generation.
  // ---------------------------------------------------------------------------
  function automatic int rand_comp();
    return int'($urandom_range(0, 32768)) - 16384;
  endfunction

  function automatic logic signed [QB-1:0] to_q14(input real v);
    int r;
    r = $rtoi(v * 16384.0 + (v >= 0 ? 0.5 : -0.5));
    if (r > 16384)  r = 16384;
    if (r < -16384) r = -16384;
    return r[QB-1:0];
  endfunction

  task automatic push_quat(input int w, input int x, input int y, input int z);
    quat_t q;
    q.w = w[QB-1:0]; q.x = x[QB-1:0]; q.y = y[QB-1:0]; q.z = z[QB-1:0];
    quat_q.push_back(q);
  endtask

  task automatic push_random(input quat_shape_t shape);
    real v[4], n;
    quat_t q;
    int a, sg;
    case (shape)
      SHAPE_UNIT: begin
        do begin
          n = 0.0;
          foreach (v[i]) begin
            v[i] = (real'($urandom_range(0, 2000)) - 1000.0) / 1000.0;
            n += v[i] * v[i];
          end
        end while (n < 0.01);
        n = $sqrt(n);
        q.w = to_q14(v[0] / n); q.x = to_q14(v[1] / n);
        q.y = to_q14(v[2] / n); q.z = to_q14(v[3] / n);
        quat_q.push_back(q);
      end
      SHAPE_NEAR_LOCK: begin
        // Pitch sine near +-1: w and x close in magnitude, or y and z.
        a  = 11585 + int'($urandom_range(0, 400)) - 200;
        sg = $urandom_range(0, 1) ? 1 : -1;
        if ($urandom_range(0, 1))
          push_quat(a, sg * (a + int'($urandom_range(0, 600)) - 300),
                    int'($urandom_range(0, 800)) - 400, int'($urandom_range(0, 800)) - 400);
        else
          push_quat(int'($urandom_range(0, 800)) - 400, int'($urandom_range(0, 800)) - 400,
                    a, sg * (a + int'($urandom_range(0, 600)) - 300));
      end
      default: push_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
    endcase
  endtask

  task automatic push_random_mix(input int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)      push_random(SHAPE_UNIT);
      else if (pick < 85) push_random(SHAPE_NEAR_LOCK);
      else                push_random(SHAPE_RAW);
    end
  endtask

  // Hold until every queued beat is out and every expected result is back,
  // then let the pipeline drain.
  task automatic wait_idle();
    wait (quat_q.size() == 0 && !in_if.valid && euler_expected_q.size() == 0);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic set_threshold(input logic [14:0] thr);
    threshold_q.push_back(thr);
    wait (threshold_q.size() == 0);
    @(posedge clk);
    wait (!cfg_if.valid);
    @(posedge clk);
  endtask

  initial begin
    logic [14:0] phase_thr[5];
    in_if.valid = 1'b0;
    in_if.quat_w = '0; in_if.quat_x = '0; in_if.quat_y = '0; in_if.quat_z = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.gimbal_threshold = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats at the reset threshold.
    push_quat(0, 0, 0, 0);                          // all-zero quaternion
    push_quat(16384, 0, 0, 0);                      // identity
    push_quat(-16384, 0, 0, 0);
    push_quat(0, 16384, 0, 0);                      // heading of pi, wraps negative
    push_quat(0, -16384, 0, 0);
    push_quat(0, 0, 16384, 0);
    push_quat(0, 0, -16384, 0);
    push_quat(0, 0, 0, 16384);
    push_quat(0, 0, 0, -16384);
    push_quat(16384, 16384, 16384, 16384);          // sine far below -1: clamp
    push_quat(-16384, 16384, -16384, 16384);        // sine far above +1: clamp
    push_quat(-16384, -16384, -16384, -16384);
    push_quat(11585, 11585, 0, 0);                  // sine just short of -1, negative pitch
    push_quat(11585, -11585, 0, 0);                 // sine just short of +1, positive pitch
    push_quat(0, 0, 11585, 11585);
    push_quat(0, 0, 11585, -11585);
    push_quat(11586, 11586, 0, 0);                  // barely over unity
    push_quat(8192, 8192, 8192, 8192);
    push_quat(8192, -8192, 8192, -8192);
    push_quat(16384, -16384, 16384, -16384);
    push_quat(-1, -1, -1, -1);
    wait_idle();

    // Threshold phases: extremes and the unity boundary first, then a random value.
    phase_thr[0] = 15'd0;
    phase_thr[1] = 15'h7FFF;
    phase_thr[2] = 15'd16384;
    phase_thr[3] = 15'd16383;
    phase_thr[4] = 15'($urandom_range(12000, 16384));
    foreach (phase_thr[p]) begin
      set_threshold(phase_thr[p]);
      push_random_mix(RAND_BEATS / 10);
      wait_idle();
    end

    // Remaining random beats at a mix of thresholds.
    set_threshold(15'($urandom_range(14000, 16384)));
    push_random_mix(RAND_BEATS / 4);
    wait_idle();
    set_threshold(15'($urandom_range(0, 32767)));
    push_random_mix(RAND_BEATS / 4);
    wait_idle();
    set_threshold(qte_pkg::THRESHOLD_RESET);
    push_random_mix(RAND_BEATS - 5 * (RAND_BEATS / 10) - 2 * (RAND_BEATS / 4));
    wait_idle();

    $display("Covered %0d quaternions in, %0d results out, %0d threshold writes",
             beats_in, beats_out, thresholds_set);
    $display("Results with gimbal lock: %0d, with clamped sine: %0d", locks_seen, clamps_seen);
    if (mismatch_count == 0 && euler_expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count, euler_expected_q.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5ms;
    $display("Timeout with %0d results outstanding", euler_expected_q.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
